@@ rtl/core/vks_pkg.sv @@
// Package for the vector keyframe sampler: table size, widths and sequencer states.
package vks_pkg;

  localparam int MaxKeys = 64;
  localparam int IdxW    = $clog2(MaxKeys);
  localparam int CntW    = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RD_START,
    ST_RD_END,
    ST_SETUP,
    ST_DIV,
    ST_DIV_FIX,
    ST_MUL,
    ST_MUL_ACC,
    ST_OUT
  } vks_state_t;

endpackage

@@ rtl/core/vector_keyframe_sampler_unit.sv @@
// Keyframe table with a sequenced linear interpolator for three-component vectors.
// Sequence: a sample beat scans the table one key per read-and-compare state pair,
// reads the start and end keys, then runs a 49-step restoring divider and three shared
// multiply steps; a single key or a zero span skips the divider and the multiplier.
// Throughput: one beat at a time; in_tready is low while a beat is being worked on, and
// the sequencer holds in its last state while the output register still holds a result.
// Reset (rst_n, synchronous, active low) clears the sequencer and sets key_count to 1;
// the key table is not cleared and must be written before it is read.
module vector_keyframe_sampler_unit
  import vks_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[0]
  input  logic         in_tuser,
  // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
  // key_z[133:102], sample_time[165:134], zero fill up to 167
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // zero_span[0], saturated[1]
  output logic [1:0]   out_tuser,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  out_tdata
);

  // Key table memories, one read port each, registered read data.
  logic [31:0] t_mem [MaxKeys];
  logic [31:0] x_mem [MaxKeys];
  logic [31:0] y_mem [MaxKeys];
  logic [31:0] z_mem [MaxKeys];
  logic [31:0] t_rd_r, x_rd_r, y_rd_r, z_rd_r;
  logic [IdxW-1:0] rd_addr;

  vks_state_t state_r, state_nxt;
  logic [CntW-1:0] count_r;
  logic [IdxW-1:0] seg_r, seg_nxt;
  logic [31:0] samp_r;
  logic [31:0] t0_r;
  logic [31:0] s_r [3];
  logic signed [32:0] d_r [3];
  logic [1:0] comp_r, comp_nxt;
  logic zero_r, sat_r;
  logic [5:0] step_r, step_nxt;
  // Divider state: magnitude dividend shifted out, remainder, quotient.
  logic [48:0] dvd_r, quo_r;
  logic [32:0] rem_r, dvs_r;
  logic neg_r;
  logic signed [31:0] fac_r;
  logic signed [65:0] prod_r;
  logic [31:0] res_r [3];
  logic outv_r;
  logic [95:0] out_data_r;
  logic [1:0]  out_user_r;

  logic [IdxW-1:0] last_idx;
  logic [CntW-1:0] n_eff;

  logic        wr_op;
  logic [IdxW-1:0] wr_idx;
  logic [33:0] rem_try;
  logic signed [32:0] num_s, den_s;
  logic signed [49:0] qs;
  logic signed [50:0] sum;
  logic fire;

  assign wr_op  = ~in_tuser;
  assign wr_idx = in_tdata[5:0];
  assign fire   = in_tvalid & in_tready;

  // Effective key count: zero acts as one, large acts as table size.
  always_comb begin
    if (count_r == '0) begin
      n_eff = CntW'(1);
    end else if (count_r > CntW'(MaxKeys)) begin
      n_eff = CntW'(MaxKeys);
    end else begin
      n_eff = count_r;
    end
    last_idx = IdxW'(n_eff - CntW'(1));
  end

  // Table write and read ports.
  always_ff @(posedge clk) begin
    if (fire && wr_op) begin
      t_mem[wr_idx] <= in_tdata[37:6];
      x_mem[wr_idx] <= in_tdata[69:38];
      y_mem[wr_idx] <= in_tdata[101:70];
      z_mem[wr_idx] <= in_tdata[133:102];
    end
    t_rd_r <= t_mem[rd_addr];
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
    z_rd_r <= z_mem[rd_addr];
  end

  assign num_s   = $signed({1'b0, samp_r}) - $signed({1'b0, t0_r});
  assign den_s   = $signed({1'b0, t_rd_r}) - $signed({1'b0, t0_r});
  assign rem_try = {rem_r, dvd_r[48]} - {1'b0, dvs_r};
  assign qs      = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  // Floor of the product by 2^16 plus the start value, kept wide for the clip check.
  assign sum     = $signed({{19{s_r[comp_r][31]}}, s_r[comp_r]}) + $signed(prod_r[65:16]);

  // Sequencer next state and read address.
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    rd_addr   = seg_r;
    case (state_r)
      ST_IDLE: begin
        seg_nxt = '0;
        if (fire && !wr_op) begin
          state_nxt = (n_eff == CntW'(1)) ? ST_RD_START : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        rd_addr   = seg_r + IdxW'(1);
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (samp_r < t_rd_r) begin
          state_nxt = ST_RD_START;
        end else if (seg_r + IdxW'(2) > last_idx || seg_r + IdxW'(1) == last_idx) begin
          seg_nxt   = '0;
          state_nxt = ST_RD_START;
        end else begin
          seg_nxt   = seg_r + IdxW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_RD_START: begin
        state_nxt = ST_RD_END;
      end
      ST_RD_END: begin
        rd_addr   = seg_r + IdxW'(1);
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        step_nxt = '0;
        if (n_eff == CntW'(1) || den_s == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd48) begin
          state_nxt = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        comp_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        comp_nxt = comp_r + 2'd1;
        state_nxt = (comp_r == 2'd2) ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (!outv_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= CntW'(1);
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      if (out_tvalid && out_tready) begin
        outv_r <= 1'b0;
      end
      if (state_r == ST_OUT && !outv_r) begin
        outv_r <= 1'b1;
      end
    end
  end

  // Datapath registers: shared divider step and shared multiplier.
  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    comp_r <= comp_nxt;
    step_r <= step_nxt;
    if (fire) begin
      samp_r <= in_tdata[165:134];
    end
    case (state_r)
      ST_RD_END: begin
        t0_r   <= t_rd_r;
        s_r[0] <= x_rd_r;
        s_r[1] <= y_rd_r;
        s_r[2] <= z_rd_r;
      end
      ST_SETUP: begin
        d_r[0] <= $signed({x_rd_r[31], x_rd_r}) - $signed({s_r[0][31], s_r[0]});
        d_r[1] <= $signed({y_rd_r[31], y_rd_r}) - $signed({s_r[1][31], s_r[1]});
        d_r[2] <= $signed({z_rd_r[31], z_rd_r}) - $signed({s_r[2][31], s_r[2]});
        zero_r <= (n_eff != CntW'(1)) && (den_s == '0);
        sat_r  <= 1'b0;
        neg_r  <= num_s[32] ^ den_s[32];
        dvd_r  <= {(num_s[32] ? 33'(-num_s) : 33'(num_s)), 16'd0};
        dvs_r  <= den_s[32] ? 33'(-den_s) : 33'(den_s);
        rem_r  <= '0;
        quo_r  <= '0;
        res_r[0] <= s_r[0];
        res_r[1] <= s_r[1];
        res_r[2] <= s_r[2];
      end
      ST_DIV: begin
        dvd_r <= {dvd_r[47:0], 1'b0};
        if (!rem_try[33]) begin
          rem_r <= rem_try[32:0];
          quo_r <= {quo_r[47:0], 1'b1};
        end else begin
          rem_r <= {rem_r[31:0], dvd_r[48]};
          quo_r <= {quo_r[47:0], 1'b0};
        end
      end
      ST_DIV_FIX: begin
        if (qs > 50'sh7FFFFFFF) begin
          fac_r <= 32'sh7FFFFFFF;
          sat_r <= 1'b1;
        end else if (qs < -50'sh80000000) begin
          fac_r <= -32'sh7FFFFFFF - 32'sd1;
          sat_r <= 1'b1;
        end else begin
          fac_r <= qs[31:0];
        end
      end
      ST_MUL: begin
        prod_r <= d_r[comp_r] * fac_r;
      end
      ST_MUL_ACC: begin
        // Arithmetic shift floors the product; then add start and clip.
        if (sum[50:31] != {20{sum[50]}}) begin
          res_r[comp_r] <= sum[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          sat_r <= 1'b1;
        end else begin
          res_r[comp_r] <= sum[31:0];
        end
      end
      ST_OUT: begin
        // Hand the finished beat to the output register once it is free.
        if (!outv_r) begin
          out_data_r <= {res_r[2], res_r[1], res_r[0]};
          out_user_r <= {sat_r, zero_r};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_tvalid = outv_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
